// ===== sv/rtda_pkg.sv =====
// Shared types, constants and command/status bundles of the RED admission block.
package rtda_pkg;

    localparam int QLEN_W = 11;
    localparam int TICK_W = 32;
    localparam int RND_W  = 16;
    localparam int AVG_W  = 27;
    localparam int FRAC_W = 16;
    localparam int PROB_W = 16;
    localparam int CNT_W  = 17;
    localparam int PROD_W = PROB_W + AVG_W;
    localparam int QUOT_W = 17;
    localparam int DCNT_W = 3;
    localparam int STEP_W = 5;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;

    // Queue length cap applied before averaging
    localparam logic [QLEN_W-1:0] QUEUE_DEPTH = 11'd1024;
    // 0.1 in Q0.16, applied once per elapsed tick on an empty queue
    localparam logic [12:0] DECAY_Q16 = 13'd6554;
    localparam logic [DCNT_W-1:0] DECAY_TICKS = 3'd5;
    localparam logic [QUOT_W-1:0] ONE_Q16 = 17'h10000;
    localparam logic [STEP_W-1:0] DIV_STEPS = 5'd17;
    localparam logic signed [CNT_W-1:0] COUNT_MAX = 17'sd65535;

    typedef enum logic [1:0] {
        REASON_ADMIT  = 2'd0,
        REASON_FULL   = 2'd1,
        REASON_EARLY  = 2'd2,
        REASON_FORCED = 2'd3
    } reason_t;

    typedef enum logic [2:0] {
        REG_CAPACITY = 3'd0,
        REG_RED_EN   = 3'd1,
        REG_MIN_TH   = 3'd2,
        REG_MAX_TH   = 3'd3,
        REG_MAX_PROB = 3'd4,
        REG_WEIGHT   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [QLEN_W-1:0] queue_capacity;
        logic              red_enable;
        logic [QLEN_W-1:0] min_threshold;
        logic [QLEN_W-1:0] max_threshold;
        logic [PROB_W-1:0] max_probability;
        logic [PROB_W-1:0] average_weight;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_DECAY,
        S_DECAY_WB,
        S_UPD_MUL,
        S_UPD_APPLY,
        S_CMP,
        S_PB_MUL,
        S_PB_START,
        S_PB_DIV,
        S_PB_TAKE,
        S_LOAD_MUL,
        S_PA_START,
        S_PA_DIV,
        S_PA_DECIDE,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLASS,
        OP_DECAY_MUL,
        OP_DECAY_WB,
        OP_UPD_MUL,
        OP_UPD_APPLY,
        OP_CMP,
        OP_PB_MUL,
        OP_DIV_PB,
        OP_DIV_STEP,
        OP_PB_TAKE,
        OP_LOAD_MUL,
        OP_EARLY_DROP,
        OP_DIV_PA,
        OP_PA_DECIDE,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic in_ready;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic red_off;
        logic q_empty;
        logic decay_done;
        logic ge_max;
        logic ge_min;
        logic div_last;
        logic load_big;
        logic pa_ovf;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== sv/rtda_if.sv =====
// Word channels of the RED admission block: arrivals and verdicts.
interface rtda_in_if import rtda_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [QLEN_W-1:0] queue_length;
    logic [TICK_W-1:0] now_ticks;
    logic [RND_W-1:0]  random_value;

    modport source (output valid, queue_length, now_ticks, random_value, input ready);
    modport sink   (input valid, queue_length, now_ticks, random_value, output ready);
endinterface

interface rtda_out_if import rtda_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             drop;
    logic [1:0]       drop_reason;
    logic [AVG_W-1:0] average_queue;

    modport source (output valid, drop, drop_reason, average_queue, input ready);
    modport sink   (input valid, drop, drop_reason, average_queue, output ready);
endinterface

// ===== sv/rtda_cfg.sv =====
// APB register file holding the admission settings.
module rtda_cfg import rtda_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_CAPACITY: cfg_next.queue_capacity  = pwdata[QLEN_W-1:0];
                REG_RED_EN:   cfg_next.red_enable      = pwdata[0];
                REG_MIN_TH:   cfg_next.min_threshold   = pwdata[QLEN_W-1:0];
                REG_MAX_TH:   cfg_next.max_threshold   = pwdata[QLEN_W-1:0];
                REG_MAX_PROB: cfg_next.max_probability = pwdata[PROB_W-1:0];
                REG_WEIGHT:   cfg_next.average_weight  = pwdata[PROB_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_CAPACITY: prdata = DATA_W'(cfg_reg.queue_capacity);
            REG_RED_EN:   prdata = DATA_W'(cfg_reg.red_enable);
            REG_MIN_TH:   prdata = DATA_W'(cfg_reg.min_threshold);
            REG_MAX_TH:   prdata = DATA_W'(cfg_reg.max_threshold);
            REG_MAX_PROB: prdata = DATA_W'(cfg_reg.max_probability);
            REG_WEIGHT:   prdata = DATA_W'(cfg_reg.average_weight);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.queue_capacity  <= 11'd1024;
            cfg_reg.red_enable      <= 1'b1;
            cfg_reg.min_threshold   <= 11'd256;
            cfg_reg.max_threshold   <= 11'd768;
            cfg_reg.max_probability <= 16'd6554;
            cfg_reg.average_weight  <= 16'd58982;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/rtda_dp.sv =====
// Datapath: average, count, shared multiplier and shared serial divider.
module rtda_dp import rtda_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  op_t               op,
    input  logic [QLEN_W-1:0] in_queue_length,
    input  logic [TICK_W-1:0] in_now_ticks,
    input  logic [RND_W-1:0]  in_random_value,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              out_drop,
    output logic [1:0]        out_drop_reason,
    output logic [AVG_W-1:0]  out_average_queue,
    output dp_status_t        status
);

    // Block state and control
    logic [AVG_W-1:0]        avg_reg, avg_next;
    logic signed [CNT_W-1:0] count_reg, count_next;
    logic [TICK_W-1:0]       last_reg, last_next;
    logic                    out_valid_reg, out_valid_next;

    // Working registers
    logic [QLEN_W-1:0] qlen_reg, qlen_next;
    logic [TICK_W-1:0] now_reg, now_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    reason_t           reason_reg, reason_next;
    logic [DCNT_W-1:0] dec_cnt_reg, dec_cnt_next;
    logic              up_reg, up_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [AVG_W-1:0]  div_rem_reg, div_rem_next;
    logic [QUOT_W-1:0] div_low_reg, div_low_next;
    logic [AVG_W-1:0]  div_dvs_reg, div_dvs_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [STEP_W-1:0] div_cnt_reg, div_cnt_next;
    logic [PROB_W-1:0] pb_reg, pb_next;
    logic              drop_o_reg, drop_o_next;
    reason_t           reason_o_reg, reason_o_next;
    logic [AVG_W-1:0]  avg_o_reg, avg_o_next;

    logic [QLEN_W-1:0] qcap;
    logic [AVG_W-1:0]  target, diff, min_t, max_t;
    logic              up;
    logic [TICK_W-1:0] elapsed;
    logic [PROB_W-1:0] mul_a;
    logic [AVG_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod_round;
    logic [AVG_W:0]    div_shift, div_trial;
    logic [QUOT_W-1:0] pa_den, pa;

    // Sample target and thresholds in Q11.16
    assign qcap    = (qlen_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : qlen_reg;
    assign target  = {qcap, {FRAC_W{1'b0}}};
    assign up      = target >= avg_reg;
    assign diff    = up ? target - avg_reg : avg_reg - target;
    assign min_t   = {cfg.min_threshold, {FRAC_W{1'b0}}};
    assign max_t   = {cfg.max_threshold, {FRAC_W{1'b0}}};
    assign elapsed = now_reg - last_reg;

    assign prod_round = prod_reg + PROD_W'(17'h0FFFF);
    assign div_shift  = {div_rem_reg, div_low_reg[QUOT_W-1]};
    assign div_trial  = div_shift - {1'b0, div_dvs_reg};
    assign pa_den     = ONE_Q16 - {1'b0, prod_reg[FRAC_W-1:0]};
    assign pa         = (quot_reg > ONE_Q16) ? ONE_Q16 : quot_reg;

    // Status toward the controller
    assign status.full       = qlen_reg >= cfg.queue_capacity;
    assign status.red_off    = !cfg.red_enable;
    assign status.q_empty    = qlen_reg == '0;
    assign status.decay_done = dec_cnt_reg == '0;
    assign status.ge_max     = avg_reg >= max_t;
    assign status.ge_min     = avg_reg >= min_t;
    assign status.div_last   = div_cnt_reg == STEP_W'(1);
    assign status.load_big   = |prod_reg[PROD_W-1:FRAC_W];
    assign status.pa_ovf     = QUOT_W'(pb_reg[PROB_W-1:1]) >= pa_den;
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid         = out_valid_reg;
    assign out_drop          = drop_o_reg;
    assign out_drop_reason   = reason_o_reg;
    assign out_average_queue = avg_o_reg;

    // Select multiplier operands
    always_comb
    begin
        case (op)
            OP_DECAY_MUL:
            begin
                mul_a = PROB_W'(DECAY_Q16);
                mul_b = avg_reg;
            end
            OP_UPD_MUL:
            begin
                mul_a = cfg.average_weight;
                mul_b = diff;
            end
            OP_PB_MUL:
            begin
                mul_a = cfg.max_probability;
                mul_b = avg_reg - min_t;
            end
            OP_LOAD_MUL:
            begin
                mul_a = pb_reg;
                mul_b = AVG_W'(count_reg[CNT_W-2:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Execute the current command
    always_comb
    begin
        avg_next       = avg_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        qlen_next      = qlen_reg;
        now_next       = now_reg;
        rnd_next       = rnd_reg;
        reason_next    = reason_reg;
        dec_cnt_next   = dec_cnt_reg;
        up_next        = up_reg;
        prod_next      = prod_reg;
        div_rem_next   = div_rem_reg;
        div_low_next   = div_low_reg;
        div_dvs_next   = div_dvs_reg;
        quot_next      = quot_reg;
        div_cnt_next   = div_cnt_reg;
        pb_next        = pb_reg;
        drop_o_next    = drop_o_reg;
        reason_o_next  = reason_o_reg;
        avg_o_next     = avg_o_reg;

        unique case (op)
            OP_LOAD:
            begin
                qlen_next = in_queue_length;
                now_next  = in_now_ticks;
                rnd_next  = in_random_value;
            end
            OP_CLASS:
            begin
                if (status.full)
                begin
                    reason_next = REASON_FULL;
                end
                else if (status.red_off)
                begin
                    reason_next = REASON_ADMIT;
                end
                else
                begin
                    last_next = now_reg;
                    if (elapsed >= TICK_W'(DECAY_TICKS))
                    begin
                        dec_cnt_next = '0;
                        if (status.q_empty)
                        begin
                            avg_next = '0;
                        end
                    end
                    else
                    begin
                        dec_cnt_next = elapsed[DCNT_W-1:0];
                    end
                end
            end
            OP_DECAY_MUL, OP_PB_MUL, OP_LOAD_MUL:
            begin
                prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
            end
            OP_UPD_MUL:
            begin
                prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
                up_next   = up;
            end
            OP_DECAY_WB:
            begin
                avg_next     = prod_reg[FRAC_W +: AVG_W];
                dec_cnt_next = dec_cnt_reg - DCNT_W'(1);
            end
            OP_UPD_APPLY:
            begin
                // Round the new average down: truncate a rising step, round a falling step up
                if (up_reg)
                begin
                    avg_next = avg_reg + prod_reg[FRAC_W +: AVG_W];
                end
                else
                begin
                    avg_next = avg_reg - prod_round[FRAC_W +: AVG_W];
                end
            end
            OP_CMP:
            begin
                if (status.ge_max)
                begin
                    count_next  = '0;
                    reason_next = REASON_FORCED;
                end
                else if (status.ge_min)
                begin
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    count_next  = '1;
                    reason_next = REASON_ADMIT;
                end
            end
            OP_DIV_PB:
            begin
                div_rem_next = AVG_W'(prod_reg[PROD_W-1:QUOT_W]);
                div_low_next = prod_reg[QUOT_W-1:0];
                div_dvs_next = max_t - min_t;
                quot_next    = '0;
                div_cnt_next = DIV_STEPS;
            end
            OP_DIV_PA:
            begin
                div_rem_next = AVG_W'(pb_reg[PROB_W-1:1]);
                div_low_next = {pb_reg[0], {FRAC_W{1'b0}}};
                div_dvs_next = AVG_W'(pa_den);
                quot_next    = '0;
                div_cnt_next = DIV_STEPS;
            end
            OP_DIV_STEP:
            begin
                // One restoring step: one quotient bit
                if (!div_trial[AVG_W])
                begin
                    div_rem_next = div_trial[AVG_W-1:0];
                    quot_next    = {quot_reg[QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    div_rem_next = div_shift[AVG_W-1:0];
                    quot_next    = {quot_reg[QUOT_W-2:0], 1'b0};
                end
                div_low_next = {div_low_reg[QUOT_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg - STEP_W'(1);
            end
            OP_PB_TAKE:
            begin
                pb_next = quot_reg[PROB_W-1:0];
            end
            OP_EARLY_DROP:
            begin
                count_next  = '0;
                reason_next = REASON_EARLY;
            end
            OP_PA_DECIDE:
            begin
                if ({1'b0, rnd_reg} < pa)
                begin
                    count_next  = '0;
                    reason_next = REASON_EARLY;
                end
                else
                begin
                    reason_next = REASON_ADMIT;
                end
            end
            OP_OUT:
            begin
                out_valid_next = 1'b1;
                drop_o_next    = reason_reg != REASON_ADMIT;
                reason_o_next  = reason_reg;
                avg_o_next     = avg_reg;
            end
            default:
            begin
                avg_next = avg_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg       <= '0;
            count_reg     <= '1;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            avg_reg       <= avg_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qlen_reg     <= qlen_next;
        now_reg      <= now_next;
        rnd_reg      <= rnd_next;
        reason_reg   <= reason_next;
        dec_cnt_reg  <= dec_cnt_next;
        up_reg       <= up_next;
        prod_reg     <= prod_next;
        div_rem_reg  <= div_rem_next;
        div_low_reg  <= div_low_next;
        div_dvs_reg  <= div_dvs_next;
        quot_reg     <= quot_next;
        div_cnt_reg  <= div_cnt_next;
        pb_reg       <= pb_next;
        drop_o_reg   <= drop_o_next;
        reason_o_reg <= reason_o_next;
        avg_o_reg    <= avg_o_next;
    end

endmodule

// ===== sv/rtda_ctrl.sv =====
// Controller state machine sequencing one admission decision.
module rtda_ctrl import rtda_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid) state_next = S_CLASS;
            S_CLASS:
                if (status.full || status.red_off) state_next = S_DONE;
                else if (status.q_empty)           state_next = S_DECAY;
                else                               state_next = S_UPD_MUL;
            S_DECAY:
                state_next = status.decay_done ? S_CMP : S_DECAY_WB;
            S_DECAY_WB:  state_next = S_DECAY;
            S_UPD_MUL:   state_next = S_UPD_APPLY;
            S_UPD_APPLY: state_next = S_CMP;
            S_CMP:
                if (status.ge_max || !status.ge_min) state_next = S_DONE;
                else                                 state_next = S_PB_MUL;
            S_PB_MUL:    state_next = S_PB_START;
            S_PB_START:  state_next = S_PB_DIV;
            S_PB_DIV:
                if (status.div_last) state_next = S_PB_TAKE;
            S_PB_TAKE:   state_next = S_LOAD_MUL;
            S_LOAD_MUL:  state_next = S_PA_START;
            S_PA_START:
                state_next = (status.load_big || status.pa_ovf) ? S_DONE : S_PA_DIV;
            S_PA_DIV:
                if (status.div_last) state_next = S_PA_DECIDE;
            S_PA_DECIDE: state_next = S_DONE;
            S_DONE:
                if (!status.out_busy) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd.in_ready = 1'b0;
        cmd.op       = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.op       = in_valid ? OP_LOAD : OP_NONE;
            end
            S_CLASS:     cmd.op = OP_CLASS;
            S_DECAY:     cmd.op = status.decay_done ? OP_NONE : OP_DECAY_MUL;
            S_DECAY_WB:  cmd.op = OP_DECAY_WB;
            S_UPD_MUL:   cmd.op = OP_UPD_MUL;
            S_UPD_APPLY: cmd.op = OP_UPD_APPLY;
            S_CMP:       cmd.op = OP_CMP;
            S_PB_MUL:    cmd.op = OP_PB_MUL;
            S_PB_START:  cmd.op = OP_DIV_PB;
            S_PB_DIV:    cmd.op = OP_DIV_STEP;
            S_PB_TAKE:   cmd.op = OP_PB_TAKE;
            S_LOAD_MUL:  cmd.op = OP_LOAD_MUL;
            S_PA_START:
                cmd.op = (status.load_big || status.pa_ovf) ? OP_EARLY_DROP : OP_DIV_PA;
            S_PA_DIV:    cmd.op = OP_DIV_STEP;
            S_PA_DECIDE: cmd.op = OP_PA_DECIDE;
            S_DONE:      cmd.op = status.out_busy ? OP_NONE : OP_OUT;
            default:     cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/red_tail_drop_admission.sv =====
// Top level of the RED / tail drop admission block.
//
// One word on "arrival" (queue_length, now_ticks, random_value) yields one
// word on "verdict" (drop, drop_reason, average_queue). Settings are to be
// written over the APB port while no packet is in flight; the block itself
// does not enforce this. pready is always high. A full queue or RED
// disabled goes from the classify state straight to the done state,
// skipping the average update. A RED evaluation takes one weighted-average
// multiply (or up to four decay multiplies), then, for an average between
// the thresholds, up to two serial 17-step divisions for the base and
// count-corrected probabilities on a shared restoring divider; an empty
// queue decaying four ticks with both divisions is the longest case.
// Items are processed one at a time; the next word is taken once the
// previous verdict is in the output register, which holds it while the
// receiver stalls. Reset clears the average to 0, the drop count to -1,
// the last arrival time to 0 and loads the default settings.
module red_tail_drop_admission import rtda_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    rtda_in_if.sink           arrival,
    rtda_out_if.source        verdict,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    rtda_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rtda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (arrival.valid),
        .status   (status),
        .cmd      (cmd)
    );

    rtda_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg),
        .op                (cmd.op),
        .in_queue_length   (arrival.queue_length),
        .in_now_ticks      (arrival.now_ticks),
        .in_random_value   (arrival.random_value),
        .out_ready         (verdict.ready),
        .out_valid         (verdict.valid),
        .out_drop          (verdict.drop),
        .out_drop_reason   (verdict.drop_reason),
        .out_average_queue (verdict.average_queue),
        .status            (status)
    );

    assign arrival.ready = cmd.in_ready;

endmodule
